// ----- rtl/isa_pkg.sv -----
`timescale 1ns / 1ps

package isa_pkg;

    // field widths
    localparam int COUNT_W     = 32;
    localparam int SEC_W       = 32;
    localparam int USEC_W      = 20;
    localparam int MEAN_USEC_W = 21;
    localparam int MODE_W      = 2;

    // seconds remainder times one million plus micros, below count times one million
    localparam int TOTAL_W     = 52;

    // divider steps: whole seconds by the count, then the scaled remainder by the count
    localparam int SEC_STEPS   = COUNT_W;
    localparam int USEC_STEPS  = TOTAL_W - COUNT_W;
    localparam int DIV_CNT_W   = $clog2(SEC_STEPS + 1);

    // stream widths
    localparam int S_TDATA_W   = 56;
    localparam int S_TUSER_W   = MODE_W;
    localparam int M_TDATA_W   = 192;
    localparam int M_TUSER_W   = 1;

    localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);
    localparam logic [USEC_W-1:0] USEC_MAX     = USEC_W'(999999);

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD    = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_REPORT = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_SEC,
        ST_MUL,
        ST_DIV_USEC,
        ST_FINISH
    } state_t;

    // accumulated statistics
    typedef struct packed {
        logic [COUNT_W-1:0] tally;
        logic [SEC_W-1:0]   sum_sec;
        logic [USEC_W-1:0]  sum_usec;
        logic [SEC_W-1:0]   peak_sec;
        logic [USEC_W-1:0]  peak_usec;
        logic               saturated;
    } stats_t;

    // sequencer controls to the datapath
    typedef struct packed {
        logic in_ready;
        logic mul_en;
        logic div_start;
        logic div_split;
        logic out_load;
    } seq_ctrl_t;

    // datapath status to the sequencer
    typedef struct packed {
        logic in_valid;
        logic tally_zero;
        logic div_done;
        logic out_free;
    } seq_stat_t;

endpackage

// ----- rtl/interval_statistics_accumulator.sv -----
`timescale 1ns / 1ps

// channel   dir  tdata (low bit up)                               tuser
// s_axis    in   interval_sec[31:0], interval_usec[51:32], pad    mode[1:0]
// m_axis    out  sample_count, sum_sec, sum_usec, peak_sec,       count_saturated
//                peak_usec, mean_sec, mean_usec, pad to 192
//
// a nonzero count gives the result after setup, 32 divider steps on the whole seconds,
// one multiply of their remainder by one million, 20 divider steps on the micros and a
// finish state that waits for a free result register; the next request is taken after that
// with a zero count the sequencer goes from setup straight to the finish state
// reset clears the statistics and the sequencer; the result register is free
// a stalled result holds in the output register while the next request is taken

module interval_statistics_accumulator
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // interval_sec, interval_usec, zero pad
    input  logic [isa_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // mode
    input  logic [isa_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // sample_count, sum_sec, sum_usec, peak_sec, peak_usec, mean_sec, mean_usec, zero pad
    output logic [isa_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // count_saturated
    output logic [isa_pkg::M_TUSER_W-1:0]     m_axis_tuser
);

    isa_pkg::seq_ctrl_t                 ctrl;
    isa_pkg::seq_stat_t                 stat;
    isa_pkg::stats_t                    stats;
    logic                               accept;
    logic [isa_pkg::SEC_W-1:0]          in_sec;
    logic [isa_pkg::USEC_W-1:0]         in_usec;

    logic                               neg;
    logic                               usec_zero;
    logic [isa_pkg::COUNT_W-1:0]        mag_sec;
    logic [isa_pkg::USEC_W-1:0]         mag_usec;
    logic [isa_pkg::TOTAL_W-1:0]        carry_full;
    logic [isa_pkg::TOTAL_W-1:0]        carry_reg;
    logic [isa_pkg::SEC_W-1:0]          qsec_reg;

    logic [isa_pkg::DIV_CNT_W-1:0]      div_steps;
    logic [isa_pkg::COUNT_W-1:0]        div_rem_init;
    logic [isa_pkg::COUNT_W-1:0]        div_dividend;
    logic [isa_pkg::COUNT_W-1:0]        div_quot;
    logic [isa_pkg::COUNT_W-1:0]        div_rem;
    logic                               div_done;

    logic [isa_pkg::SEC_W-1:0]          mean_sec;
    logic [isa_pkg::MEAN_USEC_W-1:0]    mean_usec;
    logic [isa_pkg::MEAN_USEC_W-1:0]    mean_usec_mag;
    logic [isa_pkg::M_TDATA_W-1:0]      out_data;

    logic                               m_valid_reg;
    logic                               m_valid_next;
    logic [isa_pkg::M_TDATA_W-1:0]      m_data_reg;
    logic [isa_pkg::M_TUSER_W-1:0]      m_user_reg;

    // input request
    assign s_axis_tready = ctrl.in_ready;
    assign accept        = s_axis_tvalid && ctrl.in_ready;
    assign in_sec        = s_axis_tdata[isa_pkg::SEC_W-1:0];
    assign in_usec       = s_axis_tdata[isa_pkg::SEC_W+isa_pkg::USEC_W-1:isa_pkg::SEC_W];

    isa_stats u_stats
    (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (accept),
        .mode  (isa_pkg::mode_t'(s_axis_tuser)),
        .sec   (in_sec),
        .usec  (in_usec),
        .stats (stats)
    );

    // sequencer status
    assign stat.in_valid   = s_axis_tvalid;
    assign stat.tally_zero = (stats.tally == '0);
    assign stat.div_done   = div_done;
    assign stat.out_free   = !m_valid_reg || m_axis_tready;

    isa_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    // magnitude of the total as whole seconds plus micros, negative when the seconds are
    assign neg       = stats.sum_sec[isa_pkg::SEC_W-1];
    assign usec_zero = (stats.sum_usec == '0);
    assign mag_sec   = neg ? (~stats.sum_sec + isa_pkg::COUNT_W'(usec_zero)) : stats.sum_sec;
    assign mag_usec  = (neg && !usec_zero) ? (isa_pkg::USEC_PER_SEC - stats.sum_usec) :
                                             stats.sum_usec;

    // seconds remainder scaled to micros, plus the micros of the magnitude
    assign carry_full = {{(isa_pkg::TOTAL_W-isa_pkg::COUNT_W){1'b0}}, div_rem} *
                        {{(isa_pkg::TOTAL_W-isa_pkg::USEC_W){1'b0}}, isa_pkg::USEC_PER_SEC} +
                        {{(isa_pkg::TOTAL_W-isa_pkg::USEC_W){1'b0}}, mag_usec};

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            carry_reg <= carry_full;
            qsec_reg  <= div_quot;
        end
    end

    // shared divider: whole seconds by the count, then the scaled remainder by the count
    assign div_steps    = ctrl.div_split ? isa_pkg::DIV_CNT_W'(isa_pkg::USEC_STEPS) :
                                           isa_pkg::DIV_CNT_W'(isa_pkg::SEC_STEPS);
    assign div_rem_init = ctrl.div_split ?
                          carry_reg[isa_pkg::TOTAL_W-1:isa_pkg::USEC_STEPS] : '0;
    assign div_dividend = ctrl.div_split ?
                          {carry_reg[isa_pkg::USEC_STEPS-1:0],
                           {(isa_pkg::COUNT_W-isa_pkg::USEC_STEPS){1'b0}}} :
                          mag_sec;

    isa_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctrl.div_start),
        .steps     (div_steps),
        .rem_init  (div_rem_init),
        .dividend  (div_dividend),
        .divisor   (stats.tally),
        .quotient  (div_quot),
        .remainder (div_rem),
        .done      (div_done)
    );

    // signed average, zero for an empty set
    assign mean_usec_mag = {1'b0, div_quot[isa_pkg::USEC_W-1:0]};

    always_comb
    begin
        if (stat.tally_zero)
        begin
            mean_sec  = '0;
            mean_usec = '0;
        end
        else if (neg)
        begin
            mean_sec  = ~qsec_reg + isa_pkg::SEC_W'(1);
            mean_usec = ~mean_usec_mag + isa_pkg::MEAN_USEC_W'(1);
        end
        else
        begin
            mean_sec  = qsec_reg;
            mean_usec = mean_usec_mag;
        end
    end

    assign out_data = {3'b000, mean_usec, mean_sec, stats.peak_usec, stats.peak_sec,
                       stats.sum_usec, stats.sum_sec, stats.tally};

    // output register
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (ctrl.out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            m_data_reg <= out_data;
            m_user_reg <= stats.saturated;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

// ----- rtl/isa_stats.sv -----
`timescale 1ns / 1ps

module isa_stats
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            upd,
    input  isa_pkg::mode_t                  mode,
    input  logic [isa_pkg::SEC_W-1:0]       sec,
    input  logic [isa_pkg::USEC_W-1:0]      usec,
    output isa_pkg::stats_t                 stats
);

    isa_pkg::stats_t                   stats_reg;
    isa_pkg::stats_t                   stats_next;
    isa_pkg::stats_t                   added;
    logic [isa_pkg::USEC_W-1:0]        usec_clip;
    logic [isa_pkg::USEC_W:0]          usec_sum;
    logic                              usec_wrap;
    logic                              new_peak;

    // clamp oversized microseconds
    assign usec_clip = (usec > isa_pkg::USEC_MAX) ? isa_pkg::USEC_MAX : usec;

    // normalized total with carry into seconds
    assign usec_sum  = {1'b0, stats_reg.sum_usec} + {1'b0, usec_clip};
    assign usec_wrap = (usec_sum >= {1'b0, isa_pkg::USEC_PER_SEC});

    // signed compare against the current maximum
    assign new_peak = ($signed(sec) > $signed(stats_reg.peak_sec)) ||
                      ((sec == stats_reg.peak_sec) && (usec_clip > stats_reg.peak_usec));

    // state after an add
    always_comb
    begin
        added = stats_reg;
        if (stats_reg.tally == {isa_pkg::COUNT_W{1'b1}})
        begin
            added.saturated = 1'b1;
        end
        else
        begin
            added.tally = stats_reg.tally + isa_pkg::COUNT_W'(1);
        end
        added.sum_usec = usec_wrap ?
                         isa_pkg::USEC_W'(usec_sum - {1'b0, isa_pkg::USEC_PER_SEC}) :
                         usec_sum[isa_pkg::USEC_W-1:0];
        added.sum_sec  = stats_reg.sum_sec + sec + isa_pkg::SEC_W'(usec_wrap);
        if (new_peak)
        begin
            added.peak_sec  = sec;
            added.peak_usec = usec_clip;
        end
    end

    // mode select
    always_comb
    begin
        stats_next = stats_reg;
        if (upd)
        begin
            case (mode)
                isa_pkg::MODE_ADD:   stats_next = added;
                isa_pkg::MODE_CLEAR: stats_next = '0;
                default:             stats_next = stats_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stats_reg <= '0;
        end
        else
        begin
            stats_reg <= stats_next;
        end
    end

    assign stats = stats_reg;

endmodule

// ----- rtl/isa_div.sv -----
`timescale 1ns / 1ps

module isa_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [isa_pkg::DIV_CNT_W-1:0]   steps,
    input  logic [isa_pkg::COUNT_W-1:0]     rem_init,
    input  logic [isa_pkg::COUNT_W-1:0]     dividend,
    input  logic [isa_pkg::COUNT_W-1:0]     divisor,
    output logic [isa_pkg::COUNT_W-1:0]     quotient,
    output logic [isa_pkg::COUNT_W-1:0]     remainder,
    output logic                            done
);

    logic [isa_pkg::COUNT_W-1:0]   dq_reg;
    logic [isa_pkg::COUNT_W-1:0]   dq_next;
    logic [isa_pkg::COUNT_W-1:0]   rem_reg;
    logic [isa_pkg::COUNT_W-1:0]   rem_next;
    logic [isa_pkg::COUNT_W-1:0]   dvs_reg;
    logic [isa_pkg::COUNT_W-1:0]   dvs_next;
    logic [isa_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [isa_pkg::DIV_CNT_W-1:0] cnt_next;
    logic                          done_reg;
    logic                          done_next;
    logic [isa_pkg::COUNT_W:0]     shifted;
    logic [isa_pkg::COUNT_W:0]     diff;
    logic                          fits;

    // one restoring step: shift in the next dividend bit, try the subtract
    assign shifted = {rem_reg, dq_reg[isa_pkg::COUNT_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    // preloaded remainder stays below the divisor, dividend bits enter msb first
    always_comb
    begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            dq_next  = dividend;
            rem_next = rem_init;
            dvs_next = divisor;
            cnt_next = steps;
        end
        else if (cnt_reg != '0)
        begin
            dq_next   = {dq_reg[isa_pkg::COUNT_W-2:0], fits};
            rem_next  = fits ? diff[isa_pkg::COUNT_W-1:0] : shifted[isa_pkg::COUNT_W-1:0];
            cnt_next  = cnt_reg - isa_pkg::DIV_CNT_W'(1);
            done_next = (cnt_reg == isa_pkg::DIV_CNT_W'(1));
        end
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // operands and partial results
    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = dq_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// ----- rtl/isa_seq.sv -----
`timescale 1ns / 1ps

module isa_seq
(
    input  logic                clk,
    input  logic                rst_n,
    input  isa_pkg::seq_stat_t  stat,
    output isa_pkg::seq_ctrl_t  ctrl
);

    isa_pkg::state_t state_reg;
    isa_pkg::state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            isa_pkg::ST_IDLE:
            begin
                if (stat.in_valid)
                begin
                    state_next = isa_pkg::ST_PREP;
                end
            end
            isa_pkg::ST_PREP:
            begin
                state_next = stat.tally_zero ? isa_pkg::ST_FINISH : isa_pkg::ST_DIV_SEC;
            end
            isa_pkg::ST_DIV_SEC:
            begin
                if (stat.div_done)
                begin
                    state_next = isa_pkg::ST_MUL;
                end
            end
            isa_pkg::ST_MUL:
            begin
                state_next = isa_pkg::ST_DIV_USEC;
            end
            isa_pkg::ST_DIV_USEC:
            begin
                if (stat.div_done)
                begin
                    state_next = isa_pkg::ST_FINISH;
                end
            end
            isa_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = isa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = isa_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            isa_pkg::ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
            end
            isa_pkg::ST_PREP:
            begin
                ctrl.div_start = !stat.tally_zero;
            end
            isa_pkg::ST_DIV_SEC:
            begin
                ctrl.mul_en = stat.div_done;
            end
            isa_pkg::ST_MUL:
            begin
                ctrl.div_start = 1'b1;
                ctrl.div_split = 1'b1;
            end
            isa_pkg::ST_FINISH:
            begin
                ctrl.out_load = stat.out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= isa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/isa_checker.sv -----
`timescale 1ns / 1ps

module isa_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [isa_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    input  logic [isa_pkg::S_TUSER_W-1:0]     s_axis_tuser,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [isa_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input  logic [isa_pkg::M_TUSER_W-1:0]     m_axis_tuser
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // one request in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    // an empty set reports all zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[31:0] == 32'd0) |->
            (m_axis_tdata == '0) && (m_axis_tuser == '0))
        else $error("empty set with nonzero fields");

    // nonnegative total gives a nonnegative average
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[63] |-> !m_axis_tdata[167] && !m_axis_tdata[188])
        else $error("average sign does not follow total");

    // saturation only with the count at its maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata[31:0] == 32'hFFFFFFFF))
        else $error("saturated flag with count below maximum");

endmodule

bind interval_statistics_accumulator isa_checker u_isa_checker (.*);
